// ----- rtl/core/ptsp_pkg.sv -----
// Package for the PES to TS packetizer: widths, constants, queue entry and
// sequencer state types. No dependencies.
package ptsp_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned COUNT_W     = 3;
	localparam int unsigned PID_W       = 13;
	localparam int unsigned CC_W        = 4;
	localparam int unsigned POS_W       = 6;
	localparam int unsigned TALLY_W     = 12;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0]         TS_SYNC    = 8'h47;
	localparam logic [3:0]         TS_CC_BASE = 4'h1;
	localparam logic [POS_W-1:0]   LAST_POS   = 6'd46;
	localparam logic [TALLY_W-1:0] TALLY_MAX  = 12'hfff;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              ending;
	} ptsp_entry_t;

	typedef enum logic {
		ST_RUN,
		ST_PAD
	} ptsp_state_t;

endpackage

// ----- rtl/core/ptsp_if.sv -----
// Channel interfaces of the packetizer: PES word input and TS word output.
// Depends on ptsp_pkg.
interface ptsp_pes_if import ptsp_pkg::*;;
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   payload_word;
	logic [COUNT_W-1:0]  byte_count;
	logic                end_of_unit;

	modport source(output valid, payload_word, byte_count, end_of_unit, input ready);
	modport sink(input valid, payload_word, byte_count, end_of_unit, output ready);
endinterface

interface ptsp_ts_if import ptsp_pkg::*;;
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   ts_word;
	logic                last_of_packet;
	logic                last_of_unit;
	logic [TALLY_W-1:0]  packets_in_unit;

	modport source(output valid, ts_word, last_of_packet, last_of_unit, packets_in_unit,
		input ready);
	modport sink(input valid, ts_word, last_of_packet, last_of_unit, packets_in_unit,
		output ready);
endinterface

// ----- rtl/core/ptsp_front.sv -----
// Front end: accepts PES words, pads short final words with 0xff and
// queues them for the sequencer. Depends on ptsp_pkg and ptsp_pes_if.
module ptsp_front import ptsp_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	ptsp_pes_if.sink     pes,
	output logic         q_valid,
	output ptsp_entry_t  q_entry,
	input  logic         q_pop
);

	localparam int unsigned PTR_W = $clog2(QueueDepth);
	localparam int unsigned CNT_W = $clog2(QueueDepth + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QueueDepth - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QueueDepth);

	ptsp_entry_t        mem_q [QueueDepth];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	ptsp_entry_t        entry_in;

	always_comb begin
		entry_in.word   = pes.payload_word;
		entry_in.ending = pes.end_of_unit;
		if (pes.end_of_unit) begin
			case (pes.byte_count)
				3'd1:    entry_in.word = {pes.payload_word[31:24], 24'hffffff};
				3'd2:    entry_in.word = {pes.payload_word[31:16], 16'hffff};
				3'd3:    entry_in.word = {pes.payload_word[31:8], 8'hff};
				default: entry_in.word = pes.payload_word;
			endcase
		end
	end

	assign pes.ready = (count_q != CNT_FULL);
	assign push      = pes.valid && pes.ready;
	assign q_valid   = (count_q != '0);
	assign q_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/ptsp_back.sv -----
// Back end: packet sequencer that emits header, payload and 0xff fill words
// into an output register. Depends on ptsp_pkg and ptsp_ts_if.
module ptsp_back import ptsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PID_W-1:0]   stream_pid,
	input  logic               q_valid,
	input  ptsp_entry_t        q_entry,
	output logic               q_pop,
	ptsp_ts_if.source          ts
);

	ptsp_state_t          state_q, state_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [CC_W-1:0]      cc_q, cc_d;
	logic                 pending_q, pending_d;
	logic [TALLY_W-1:0]   tally_q, tally_d;

	logic                 o_valid_q;
	logic [WORD_W-1:0]    o_word_q, word_d;
	logic                 o_lastp_q, lastp_d;
	logic                 o_lastu_q, lastu_d;
	logic [TALLY_W-1:0]   o_tally_q, tally_out_d;

	logic                 adv;
	logic                 emit;
	logic                 lastp;
	logic [POS_W-1:0]     pos_step;
	logic [TALLY_W-1:0]   tally_inc;
	logic [WORD_W-1:0]    hdr_word;

	assign adv       = !o_valid_q || ts.ready;
	assign lastp     = (pos_q == LAST_POS);
	assign pos_step  = lastp ? '0 : pos_q + 1'b1;
	assign tally_inc = (tally_q == TALLY_MAX) ? tally_q : tally_q + 1'b1;
	assign hdr_word  = {TS_SYNC, 1'b0, pending_q, 1'b0, stream_pid, TS_CC_BASE, cc_q};

	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		cc_d        = cc_q;
		pending_d   = pending_q;
		tally_d     = tally_q;
		word_d      = '1;
		lastp_d     = 1'b0;
		lastu_d     = 1'b0;
		tally_out_d = tally_q;
		emit        = 1'b0;
		q_pop       = 1'b0;
		if (adv) begin
			case (state_q)
				ST_RUN: begin
					if (q_valid) begin
						emit = 1'b1;
						if (pos_q == '0) begin
							word_d      = hdr_word;
							cc_d        = cc_q + 1'b1;
							pending_d   = 1'b0;
							tally_d     = tally_inc;
							tally_out_d = tally_inc;
							pos_d       = pos_step;
						end else begin
							q_pop   = 1'b1;
							word_d  = q_entry.word;
							lastp_d = lastp;
							lastu_d = lastp && q_entry.ending;
							pos_d   = pos_step;
							if (q_entry.ending) begin
								if (lastp) begin
									pending_d = 1'b1;
									tally_d   = '0;
								end else begin
									state_d = ST_PAD;
								end
							end
						end
					end
				end
				ST_PAD: begin
					emit    = 1'b1;
					word_d  = '1;
					lastp_d = lastp;
					lastu_d = lastp;
					pos_d   = pos_step;
					if (lastp) begin
						state_d   = ST_RUN;
						pending_d = 1'b1;
						tally_d   = '0;
					end
				end
				default: state_d = ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			pos_q     <= '0;
			cc_q      <= '0;
			pending_q <= 1'b1;
			tally_q   <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			cc_q      <= cc_d;
			pending_q <= pending_d;
			tally_q   <= tally_d;
			if (adv) begin
				o_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			o_word_q  <= word_d;
			o_lastp_q <= lastp_d;
			o_lastu_q <= lastu_d;
			o_tally_q <= tally_out_d;
		end
	end

	assign ts.valid           = o_valid_q;
	assign ts.ts_word         = o_word_q;
	assign ts.last_of_packet  = o_lastp_q;
	assign ts.last_of_unit    = o_lastu_q;
	assign ts.packets_in_unit = o_tally_q;

endmodule

// ----- rtl/core/pes_to_ts_packetizer.sv -----
// Top level of the PES to TS packetizer: PID register, front queue and
// packet sequencer. Depends on ptsp_pkg, ptsp_if, ptsp_front, ptsp_back.
//
// Usage:
//   pes: PES unit as 32-bit words, first byte in bits 31:24; end_of_unit
//        marks the final word, whose byte_count (1..4) sets the valid bytes.
//   ts:  188-byte transport packets as 47 words (header word, then 46
//        payload words). Unused bytes after the unit's end read 0xff.
//   cfg_we/cfg_wdata: write the 13-bit PID; write only while idle. The new
//        PID is used from the next header on.
// Path: a pes word passes the front queue and the sequencer's output register
//   on its way to ts; at packet start a header word goes out ahead of it.
// Throughput: one ts word per cycle from a single sequencer while ts is ready
//   and the queue holds a word (fill needs none); a final word is followed by
//   up to 45 fill words, during which pes fills the queue and then stalls.
// Reset: PID 0, continuity counter 0, next packet starts a unit, queue empty.
// Stall: a held ts word stops the sequencer; pes keeps going until the
//   queue is full.
module pes_to_ts_packetizer import ptsp_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PID_W-1:0]  cfg_wdata,
	ptsp_pes_if.sink          pes,
	ptsp_ts_if.source         ts
);

	logic [PID_W-1:0]  stream_pid_q;
	logic              q_valid;
	ptsp_entry_t       q_entry;
	logic              q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_pid_q <= '0;
		end else if (cfg_we) begin
			stream_pid_q <= cfg_wdata;
		end
	end

	ptsp_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pes     (pes),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	ptsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream_pid (stream_pid_q),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop),
		.ts         (ts)
	);

	a_unit_end_on_packet_end: assert property (@(posedge clk) disable iff (!arst_n)
		ts.valid && ts.last_of_unit |-> ts.last_of_packet)
		else $error("last_of_unit without last_of_packet");

	a_push_fills_queue: assert property (@(posedge clk) disable iff (!arst_n)
		pes.valid && pes.ready |=> q_valid)
		else $error("queue empty after a pes transaction");

	a_header_follows_packet: assert property (@(posedge clk) disable iff (!arst_n)
		ts.valid && ts.ready && ts.last_of_packet |=> !ts.valid || ts.ts_word[31:24] == TS_SYNC)
		else $error("packet not followed by a header word");

endmodule

// ----- sim/tb.sv -----
// Testbench for pes_to_ts_packetizer: feeds PES units with random gaps and stalls,
// predicts every TS word and checks the ts channel field by field.
// Depends on ptsp_pkg, ptsp_if and the packetizer RTL.
module tb;
	import ptsp_pkg::*;

	localparam int unsigned       CYCLE_LIMIT = 1000000;
	localparam logic [7:0]        PUSI_BIT    = 8'h40;
	localparam logic [WORD_W-1:0] FILL_WORD   = 32'hffff_ffff;

	typedef struct {
		logic [WORD_W-1:0]  word;
		logic [COUNT_W-1:0] count;
		logic               ending;
	} pes_item_t;

	typedef struct {
		logic [WORD_W-1:0]  word;
		logic               last_of_packet;
		logic               last_of_unit;
		logic [TALLY_W-1:0] packets;
	} ts_beat_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [PID_W-1:0] cfg_wdata;

	ptsp_pes_if pes();
	ptsp_ts_if  ts();

	pes_item_t pes_pending[$];
	ts_beat_t  ts_words_due[$];
	int        errors = 0;
	int        cycles = 0;
	int        pes_gap;
	int        ts_hold;
	bit        no_idle;

	// packetizer state as predicted
	logic [PID_W-1:0]   pid_model;
	logic [CC_W-1:0]    cc_model;
	logic [POS_W-1:0]   pos_model;
	logic               unit_start;
	logic [TALLY_W-1:0] tally_model;

	pes_to_ts_packetizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pes      (pes),
		.ts       (ts)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("** pes_to_ts_packetizer: FAILED **");
		$finish;
	end

	function automatic int draw_wait();
		if (no_idle || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic void emit_ts_word(input logic [WORD_W-1:0] w, input logic ending);
		logic lastp;
		lastp = (pos_model == LAST_POS);
		pos_model = lastp ? '0 : pos_model + 1'b1;
		ts_words_due.push_back('{word: w, last_of_packet: lastp,
			last_of_unit: lastp && ending, packets: tally_model});
	endfunction

	function automatic void packetize_word(input logic [WORD_W-1:0] data,
		input logic [COUNT_W-1:0] cnt, input logic ending);
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] fill;
		logic [7:0]        b1;
		int                n;
		n = (ending && cnt >= 1 && cnt <= 4) ? cnt : 4;
		w = data;
		if (n < 4) begin
			fill = FILL_WORD >> (8 * n);
			w = (w & ~fill) | fill;
		end
		if (pos_model == 0) begin
			b1 = {3'b000, pid_model[12:8]};
			if (unit_start)
				b1 = b1 | PUSI_BIT;
			if (tally_model != TALLY_MAX)
				tally_model = tally_model + 1'b1;
			emit_ts_word({TS_SYNC, b1, pid_model[7:0], TS_CC_BASE, cc_model}, ending);
			cc_model = cc_model + 1'b1;
			unit_start = 1'b0;
		end
		emit_ts_word(w, ending);
		if (ending) begin
			while (pos_model != 0)
				emit_ts_word(FILL_WORD, 1'b1);
			unit_start = 1'b1;
			tally_model = '0;
		end
	endfunction

	always @(posedge clk) begin : drive_pes
		pes_item_t nxt;
		if (!arst_n) begin
			pes.valid <= 1'b0;
			pes_gap <= 0;
		end else if (!pes.valid || pes.ready) begin
			if (pes.valid)
				packetize_word(pes.payload_word, pes.byte_count, pes.end_of_unit);
			if (pes_gap != 0) begin
				pes.valid <= 1'b0;
				pes_gap <= pes_gap - 1;
			end else if (pes_pending.size() != 0) begin
				nxt = pes_pending.pop_front();
				pes.payload_word <= nxt.word;
				pes.byte_count <= nxt.count;
				pes.end_of_unit <= nxt.ending;
				pes.valid <= 1'b1;
				pes_gap <= draw_wait();
			end else begin
				pes.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_ts
		ts_beat_t due;
		int       h;
		if (!arst_n) begin
			ts.ready <= 1'b0;
			ts_hold <= 0;
		end else if (ts.ready) begin
			if (ts.valid) begin
				if (ts_words_due.size() == 0) begin
					$error("unexpected ts transaction, ts_word %h", ts.ts_word);
					errors++;
				end else begin
					due = ts_words_due.pop_front();
					if (ts.ts_word !== due.word) begin
						$error("ts_word: expected %h, got %h", due.word, ts.ts_word);
						errors++;
					end
					if (ts.last_of_packet !== due.last_of_packet) begin
						$error("last_of_packet: expected %b, got %b", due.last_of_packet,
							ts.last_of_packet);
						errors++;
					end
					if (ts.last_of_unit !== due.last_of_unit) begin
						$error("last_of_unit: expected %b, got %b", due.last_of_unit,
							ts.last_of_unit);
						errors++;
					end
					if (ts.packets_in_unit !== due.packets) begin
						$error("packets_in_unit: expected %0d, got %0d", due.packets,
							ts.packets_in_unit);
						errors++;
					end
				end
				h = draw_wait();
				if (h != 0) begin
					ts.ready <= 1'b0;
					ts_hold <= h - 1;
				end
			end
		end else if (ts_hold == 0) begin
			ts.ready <= 1'b1;
		end else begin
			ts_hold <= ts_hold - 1;
		end
	end

	task automatic push_word(input logic [WORD_W-1:0] w, input logic [COUNT_W-1:0] c,
		input logic e);
		pes_pending.push_back('{word: w, count: c, ending: e});
	endtask

	task automatic add_random_unit(input int len);
		logic [COUNT_W-1:0] c;
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				c = ($urandom_range(0, 3) != 0) ? COUNT_W'($urandom_range(1, 4))
					: COUNT_W'($urandom_range(0, 7));
			else
				c = ($urandom_range(0, 3) != 0) ? COUNT_W'(4)
					: COUNT_W'($urandom_range(0, 7));
			push_word($urandom, c, i == len - 1);
		end
	endtask

	task automatic random_phase(input int target, input bit boundary_unit);
		int sent;
		int len;
		sent = 0;
		// 46 payload words close the first packet exactly
		if (boundary_unit) begin
			add_random_unit(46);
			sent = 46;
		end
		while (sent < target) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 50) : $urandom_range(1, 12);
			add_random_unit(len);
			sent += len;
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pes_pending.size() != 0 || pes.valid || ts_words_due.size() != 0);
	endtask

	task automatic set_pid(input logic [PID_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pid_model = v;
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pes.valid = 1'b0;
		pes.payload_word = '0;
		pes.byte_count = '0;
		pes.end_of_unit = 1'b0;
		ts.ready = 1'b0;
		no_idle = 1'b0;
		pid_model = '0;
		cc_model = '0;
		pos_model = '0;
		unit_start = 1'b1;
		tally_model = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset PID: partial final words, bad end counts, short word mid-unit
		push_word(32'h0123_4567, 3'd1, 1'b1);
		push_word(32'h0000_0000, 3'd4, 1'b1);
		push_word(32'hffff_ffff, 3'd4, 1'b1);
		push_word(32'h89ab_cdef, 3'd1, 1'b0);
		push_word(32'h1357_9bdf, 3'd2, 1'b1);
		push_word(32'hdead_beef, 3'd0, 1'b1);
		push_word(32'hcafe_f00d, 3'd7, 1'b1);
		wait_drained();

		set_pid(13'h1fff);
		push_word(32'h2468_ace0, 3'd3, 1'b1);
		push_word(32'h1111_2222, 3'd5, 1'b1);
		push_word(32'h3333_4444, 3'd6, 1'b1);
		push_word(32'haaaa_aaaa, 3'd6, 1'b0);
		push_word(32'h5555_5555, 3'd4, 1'b0);
		push_word(32'hf0f0_0f0f, 3'd2, 1'b1);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				1: set_pid(13'h0000);
				3: set_pid(13'h1fff);
				default: set_pid(PID_W'($urandom_range(1, 8190)));
			endcase
			no_idle = (p == 2);
			random_phase((p == 0) ? 50 : 28, p == 0);
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("** pes_to_ts_packetizer: PASSED **");
		else
			$display("** pes_to_ts_packetizer: FAILED **");
		$finish;
	end

endmodule

// ----- pes_to_ts_packetizer.f -----
rtl/core/ptsp_pkg.sv
rtl/core/ptsp_if.sv
rtl/core/ptsp_front.sv
rtl/core/ptsp_back.sv
rtl/core/pes_to_ts_packetizer.sv
sim/tb.sv
